FILE: hdl/bpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

  // Field widths of the request, response and configuration ports
  localparam int ID_W    = 12;
  localparam int PRIO_W  = 32;
  localparam int LIVE_W  = 13;
  localparam int CFG_W   = 13;
  localparam int SHIFT_W = 5;

  localparam logic [PRIO_W-1:0] PRIO_NONE = '1;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_MEM  = 2'd2
  } status_t;

  typedef enum logic {
    REG_NODE_COUNT   = 1'b0,
    REG_BUCKET_SHIFT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_NODE,
    S_PUSH_LINK,
    S_POP_START,
    S_POP_HEAD,
    S_POP_ENT,
    S_POP_VAL,
    S_POP_REL,
    S_POP_END,
    S_POP_TAKE,
    S_QRY_CHK,
    S_QRY_NODE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/bpq_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation on the queue
interface bpq_req_if;
  import bpq_pkg::*;
  logic               valid;
  logic               ready;
  mode_t              mode;
  logic [ID_W-1:0]    node_id;
  logic [PRIO_W-1:0]  priority_req;

  modport source (output valid, mode, node_id, priority_req, input ready);
  modport sink   (input valid, mode, node_id, priority_req, output ready);
endinterface

// Response channel: one answer per request
interface bpq_res_if;
  import bpq_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ID_W-1:0]    out_node;
  logic [PRIO_W-1:0]  out_priority;
  logic               present;
  logic [LIVE_W-1:0]  live_count;

  modport source (output valid, status, out_node, out_priority, present, live_count,
                  input ready);
  modport sink   (input valid, status, out_node, out_priority, present, live_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/bpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/bucket_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bucket priority queue of node ids with decrease-key by lazy deletion. All
// state sits in four single-read RAMs (bucket heads, entry payload, entry
// links, per-node best priority and queued flag), and one request is worked
// at a time by walking those RAMs. A clear sweeps every bucket head and node
// flag back to empty; after reset the same sweep runs before the first
// request is taken. A pop steps over empty buckets from the cursor, visits
// each entry of a scanned bucket and frees every stale entry it finds, and a
// pop that runs past the last bucket answers invalid; the pop time is set by
// the one-entry-at-a-time list walk through the link RAM. The free list of
// pool entries is tracked with a high-water mark, so it needs no
// initialization. A new request is accepted while the previous response
// still waits in the output register.
module bucket_priority_queue #(
  parameter int NODES        = 4096,
  parameter int BUCKETS      = 16384,
  parameter int POOL_ENTRIES = 8192
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bpq_req_if.sink                        in_ch,
  bpq_res_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire bpq_pkg::cfg_reg_t         cfg_index,
  input  wire logic [bpq_pkg::CFG_W-1:0] cfg_wdata
);
  import bpq_pkg::*;

  localparam int NW   = $clog2(NODES);
  localparam int BW   = $clog2(BUCKETS);
  localparam int EAW  = $clog2(POOL_ENTRIES);
  localparam int EW   = $clog2(POOL_ENTRIES + 1);
  localparam int CW   = $clog2(NODES + 1);
  localparam int CLRN = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int SW   = $clog2(CLRN + 1);

  localparam logic [EW-1:0] NO_ENTRY    = EW'(POOL_ENTRIES);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

  // Control and request registers
  state_t              state_r, state_nxt;
  logic [SW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [PRIO_W-1:0]   prio_r, prio_nxt;
  logic [CFG_W-1:0]    node_count_r;
  logic [SHIFT_W-1:0]  shift_r;

  // Queue bookkeeping
  logic [EW-1:0]       free_head_r, free_head_nxt;
  logic [EW-1:0]       fresh_r, fresh_nxt;
  logic [BW-1:0]       cursor_r, cursor_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  // Push and scan working registers
  logic                queued_r, queued_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic [EW-1:0]       cur_r, cur_nxt;
  logic [EW-1:0]       prev_r, prev_nxt;
  logic [EW-1:0]       nx_r, nx_nxt;
  logic [NW-1:0]       ent_node_r, ent_node_nxt;
  logic [PRIO_W-1:0]   ent_prio_r, ent_prio_nxt;
  logic [EW-1:0]       best_r, best_nxt;
  logic [EW-1:0]       best_prev_r, best_prev_nxt;
  logic [EW-1:0]       best_next_r, best_next_nxt;
  logic [NW-1:0]       best_node_r, best_node_nxt;
  logic [PRIO_W-1:0]   best_prio_r, best_prio_nxt;

  // Response being built and output register
  status_t             res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_node_r, res_node_nxt;
  logic [PRIO_W-1:0]   res_prio_r, res_prio_nxt;
  logic                res_present_r, res_present_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [ID_W-1:0]     out_node_r;
  logic [PRIO_W-1:0]   out_prio_r;
  logic                out_present_r;
  logic [LIVE_W-1:0]   out_live_r;

  // RAM ports
  logic                head_we;
  logic [BW-1:0]       head_waddr, head_raddr;
  logic [EW-1:0]       head_wdata, head_rdata;
  logic                ent_we;
  logic [EAW-1:0]      ent_waddr, ent_raddr;
  logic [NW+PRIO_W-1:0] ent_wdata, ent_rdata;
  logic                next_we;
  logic [EAW-1:0]      next_waddr, next_raddr;
  logic [EW-1:0]       next_wdata, next_rdata;
  logic                node_we;
  logic [NW-1:0]       node_waddr, node_raddr;
  logic [PRIO_W:0]     node_wdata, node_rdata;

  // Decoded values
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                clr_last;
  logic                id_ok;
  logic                node_q;
  logic [PRIO_W-1:0]   node_best;
  logic                push_skip;
  logic                free_empty;
  logic [PRIO_W-1:0]   shifted;
  logic [BW-1:0]       push_bucket;
  logic                ent_valid;
  logic                take_better;
  logic                pick_fresh;

  bpq_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  bpq_ram #(.WIDTH(NW + PRIO_W), .DEPTH(POOL_ENTRIES)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  bpq_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata)
  );

  bpq_ram #(.WIDTH(PRIO_W + 1), .DEPTH(NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  // Handshake and decode
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = (state_r == S_DONE) && out_free;
  assign clr_last     = (clr_cnt_r == SW'(CLRN - 1));

  assign id_ok        = (32'(id_r) < 32'(node_count_r)) && (32'(id_r) < 32'(NODES));
  assign node_q       = node_rdata[PRIO_W];
  assign node_best    = node_rdata[PRIO_W-1:0];
  assign push_skip    = node_q && (prio_r >= node_best);
  assign free_empty   = (free_head_r >= NO_ENTRY);
  assign shifted      = prio_r >> shift_r;
  assign push_bucket  = (32'(shifted) > 32'(BUCKETS - 1)) ? LAST_BUCKET : BW'(shifted);
  assign ent_valid    = node_q && (node_best == ent_prio_r);
  assign take_better  = (best_r == NO_ENTRY) || (ent_prio_r < best_prio_r);
  assign pick_fresh   = (free_head_r >= fresh_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (clr_last) state_nxt = clr_reply_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.mode)
            MODE_PUSH:  state_nxt = S_PUSH_CHK;
            MODE_POP:   state_nxt = S_POP_START;
            MODE_CLEAR: state_nxt = S_INIT;
            MODE_QUERY: state_nxt = S_QRY_CHK;
          endcase
        end
      end
      S_PUSH_CHK:  state_nxt = id_ok ? S_PUSH_NODE : S_DONE;
      S_PUSH_NODE: state_nxt = (push_skip || free_empty) ? S_DONE : S_PUSH_LINK;
      S_PUSH_LINK: state_nxt = S_DONE;
      S_POP_START: state_nxt = (count_r == '0) ? S_DONE : S_POP_HEAD;
      S_POP_HEAD:  state_nxt = (head_rdata == NO_ENTRY) ? S_POP_END : S_POP_ENT;
      S_POP_ENT:   state_nxt = S_POP_VAL;
      S_POP_VAL: begin
        if (!ent_valid)            state_nxt = S_POP_REL;
        else if (nx_r == NO_ENTRY) state_nxt = S_POP_END;
        else                       state_nxt = S_POP_ENT;
      end
      S_POP_REL:   state_nxt = (nx_r == NO_ENTRY) ? S_POP_END : S_POP_ENT;
      S_POP_END: begin
        if (best_r != NO_ENTRY)           state_nxt = S_POP_TAKE;
        else if (cursor_r != LAST_BUCKET) state_nxt = S_POP_HEAD;
        else                              state_nxt = S_DONE;
      end
      S_POP_TAKE:  state_nxt = S_DONE;
      S_QRY_CHK:   state_nxt = id_ok ? S_QRY_NODE : S_DONE;
      S_QRY_NODE:  state_nxt = S_DONE;
      S_DONE:      state_nxt = out_free ? S_IDLE : S_DONE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    clr_cnt_nxt     = clr_cnt_r;
    clr_reply_nxt   = clr_reply_r;
    id_nxt          = id_r;
    prio_nxt        = prio_r;
    free_head_nxt   = free_head_r;
    fresh_nxt       = fresh_r;
    cursor_nxt      = cursor_r;
    count_nxt       = count_r;
    queued_nxt      = queued_r;
    bucket_nxt      = bucket_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    nx_nxt          = nx_r;
    ent_node_nxt    = ent_node_r;
    ent_prio_nxt    = ent_prio_r;
    best_nxt        = best_r;
    best_prev_nxt   = best_prev_r;
    best_next_nxt   = best_next_r;
    best_node_nxt   = best_node_r;
    best_prio_nxt   = best_prio_r;
    res_status_nxt  = res_status_r;
    res_node_nxt    = res_node_r;
    res_prio_nxt    = res_prio_r;
    res_present_nxt = res_present_r;

    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    head_raddr = '0;
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = '0;
    ent_raddr  = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    next_raddr = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;

    unique case (state_r)
      // Sweep bucket heads and node flags back to empty, then reset the free list, cursor and live count
      S_INIT: begin
        head_we    = (32'(clr_cnt_r) < 32'(BUCKETS));
        head_waddr = clr_cnt_r[BW-1:0];
        head_wdata = NO_ENTRY;
        node_we    = (32'(clr_cnt_r) < 32'(NODES));
        node_waddr = clr_cnt_r[NW-1:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          clr_cnt_nxt   = '0;
          clr_reply_nxt = 1'b0;
          free_head_nxt = '0;
          fresh_nxt     = '0;
          cursor_nxt    = '0;
          count_nxt     = '0;
        end
      end

      // Capture the request and preset a neutral response
      S_IDLE: begin
        if (in_acc) begin
          id_nxt          = in_ch.node_id;
          prio_nxt        = in_ch.priority_req;
          res_status_nxt  = ST_OK;
          res_node_nxt    = '0;
          res_prio_nxt    = PRIO_NONE;
          res_present_nxt = 1'b0;
          clr_reply_nxt   = (in_ch.mode == MODE_CLEAR);
        end
      end

      S_PUSH_CHK: begin
        node_raddr = NW'(id_r);
        if (!id_ok) res_status_nxt = ST_INVALID;
      end

      S_PUSH_NODE: begin
        queued_nxt = node_q;
        bucket_nxt = push_bucket;
        head_raddr = push_bucket;
        next_raddr = free_head_r[EAW-1:0];
        if (!push_skip && free_empty) res_status_nxt = ST_NO_MEM;
      end

      // Prepend the new entry to its bucket
      S_PUSH_LINK: begin
        ent_we     = 1'b1;
        ent_waddr  = free_head_r[EAW-1:0];
        ent_wdata  = {NW'(id_r), prio_r};
        next_we    = 1'b1;
        next_waddr = free_head_r[EAW-1:0];
        next_wdata = head_rdata;
        head_we    = 1'b1;
        head_waddr = bucket_r;
        head_wdata = free_head_r;
        node_we    = 1'b1;
        node_waddr = NW'(id_r);
        node_wdata = {1'b1, prio_r};
        if (pick_fresh) begin
          free_head_nxt = free_head_r + 1'b1;
          fresh_nxt     = free_head_r + 1'b1;
        end else begin
          free_head_nxt = next_rdata;
        end
        if (!queued_r) count_nxt = count_r + 1'b1;
        if (bucket_r < cursor_r) cursor_nxt = bucket_r;
      end

      S_POP_START: begin
        head_raddr    = cursor_r;
        best_nxt      = NO_ENTRY;
        prev_nxt      = NO_ENTRY;
        if (count_r == '0) res_status_nxt = ST_INVALID;
      end

      S_POP_HEAD: begin
        cur_nxt    = head_rdata;
        ent_raddr  = head_rdata[EAW-1:0];
        next_raddr = head_rdata[EAW-1:0];
      end

      S_POP_ENT: begin
        ent_node_nxt = ent_rdata[NW+PRIO_W-1:PRIO_W];
        ent_prio_nxt = ent_rdata[PRIO_W-1:0];
        nx_nxt       = next_rdata;
        node_raddr   = ent_rdata[NW+PRIO_W-1:PRIO_W];
      end

      // Keep a live entry, or unlink a stale one
      S_POP_VAL: begin
        if (ent_valid) begin
          if (take_better) begin
            best_nxt      = cur_r;
            best_prev_nxt = prev_r;
            best_next_nxt = nx_r;
            best_node_nxt = ent_node_r;
            best_prio_nxt = ent_prio_r;
          end
          prev_nxt   = cur_r;
          cur_nxt    = nx_r;
          ent_raddr  = nx_r[EAW-1:0];
          next_raddr = nx_r[EAW-1:0];
        end else begin
          if (prev_r == NO_ENTRY) begin
            head_we    = 1'b1;
            head_waddr = cursor_r;
            head_wdata = nx_r;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_r[EAW-1:0];
            next_wdata = nx_r;
            if (prev_r == best_r) best_next_nxt = nx_r;
          end
        end
      end

      // Return the stale entry to the free list
      S_POP_REL: begin
        next_we       = 1'b1;
        next_waddr    = cur_r[EAW-1:0];
        next_wdata    = free_head_r;
        free_head_nxt = cur_r;
        cur_nxt       = nx_r;
        ent_raddr     = nx_r[EAW-1:0];
        next_raddr    = nx_r[EAW-1:0];
      end

      S_POP_END: begin
        if (best_r != NO_ENTRY) begin
          if (best_prev_r == NO_ENTRY) begin
            head_we    = 1'b1;
            head_waddr = cursor_r;
            head_wdata = best_next_r;
          end else begin
            next_we    = 1'b1;
            next_waddr = best_prev_r[EAW-1:0];
            next_wdata = best_next_r;
          end
        end else if (cursor_r != LAST_BUCKET) begin
          cursor_nxt = cursor_r + 1'b1;
          head_raddr = cursor_r + 1'b1;
          best_nxt   = NO_ENTRY;
          prev_nxt   = NO_ENTRY;
        end else begin
          res_status_nxt = ST_INVALID;
        end
      end

      // Free the winner and dequeue its node
      S_POP_TAKE: begin
        next_we       = 1'b1;
        next_waddr    = best_r[EAW-1:0];
        next_wdata    = free_head_r;
        free_head_nxt = best_r;
        node_we       = 1'b1;
        node_waddr    = best_node_r;
        node_wdata    = {1'b0, best_prio_r};
        count_nxt     = count_r - 1'b1;
        res_node_nxt  = ID_W'(best_node_r);
        res_prio_nxt  = best_prio_r;
      end

      S_QRY_CHK: begin
        node_raddr = NW'(id_r);
        if (!id_ok) res_status_nxt = ST_INVALID;
      end

      S_QRY_NODE: begin
        res_present_nxt = node_q;
        if (node_q) res_prio_nxt = node_best;
      end

      S_DONE: begin
      end

      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_cnt_r    <= '0;
      clr_reply_r  <= 1'b0;
      free_head_r  <= '0;
      fresh_r      <= '0;
      cursor_r     <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      node_count_r <= CFG_W'(4096);
      shift_r      <= SHIFT_W'(7);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NODE_COUNT:   node_count_r <= cfg_wdata;
          REG_BUCKET_SHIFT: shift_r      <= cfg_wdata[SHIFT_W-1:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    prio_r        <= prio_nxt;
    queued_r      <= queued_nxt;
    bucket_r      <= bucket_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    nx_r          <= nx_nxt;
    ent_node_r    <= ent_node_nxt;
    ent_prio_r    <= ent_prio_nxt;
    best_r        <= best_nxt;
    best_prev_r   <= best_prev_nxt;
    best_next_r   <= best_next_nxt;
    best_node_r   <= best_node_nxt;
    best_prio_r   <= best_prio_nxt;
    res_status_r  <= res_status_nxt;
    res_node_r    <= res_node_nxt;
    res_prio_r    <= res_prio_nxt;
    res_present_r <= res_present_nxt;
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_node_r    <= res_node_r;
      out_prio_r    <= res_prio_r;
      out_present_r <= res_present_r;
      out_live_r    <= LIVE_W'(count_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_node     = out_node_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.present      = out_present_r;
  assign out_ch.live_count   = out_live_r;

`ifndef NO_ASSERTIONS
  // An accepted request always leaves idle
  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("request accepted without starting work");

  // A finished response is loaded into a free output slot
  a_resp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("response lost at output register");

  // Removing the minimum needs a winner
  a_take_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_TAKE |-> best_r != NO_ENTRY && count_r != '0)
    else $error("pop removes without a valid entry");

  // A successful pop lowers the live count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_TAKE |=> count_r == $past(count_r) - 1'b1)
    else $error("live count not decremented on pop");

  // The free list head never passes the fresh mark
  a_free_mark: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_INIT |-> free_head_r <= fresh_r || free_head_r == NO_ENTRY)
    else $error("free list head beyond untouched pool region");
`endif

endmodule

`default_nettype wire
